FILE: hdl/acl_pkg.sv
// ----------------------------------------------------------------------------
// acl_pkg
// Shared types, codes and helpers for the access-control list checker.
// ----------------------------------------------------------------------------
package acl_pkg;

    localparam int unsigned ID_W   = 32;
    localparam int unsigned TAG_W  = 3;
    localparam int unsigned PERM_W = 3;
    localparam int unsigned VERD_W = 2;

    localparam logic [TAG_W-1:0] TAG_OWNER  = 3'd0;
    localparam logic [TAG_W-1:0] TAG_USER   = 3'd1;
    localparam logic [TAG_W-1:0] TAG_GROUPO = 3'd2;
    localparam logic [TAG_W-1:0] TAG_GROUP  = 3'd3;
    localparam logic [TAG_W-1:0] TAG_MASK   = 3'd4;
    localparam logic [TAG_W-1:0] TAG_OTHER  = 3'd5;

    localparam logic [VERD_W-1:0] V_GRANT = 2'd0;
    localparam logic [VERD_W-1:0] V_DENY  = 2'd1;
    localparam logic [VERD_W-1:0] V_EIO   = 2'd2;

    typedef enum logic [1:0] {
        PH_SCAN  = 2'd0,
        PH_MASK  = 2'd1,
        PH_DRAIN = 2'd2
    } phase_t;

    typedef struct packed {
        logic [TAG_W-1:0]  entry_tag;
        logic [PERM_W-1:0] entry_perm;
        logic [ID_W-1:0]   entry_id;
        logic              caller_member;
        logic [ID_W-1:0]   caller_uid;
        logic [ID_W-1:0]   owner_uid;
        logic [PERM_W-1:0] want;
        logic              last_entry;
        logic              list_empty;
    } acl_item_t;

    typedef struct packed {
        phase_t            phase;
        logic              group_found;
        logic [PERM_W-1:0] held_perm;
    } acl_state_t;

    typedef struct packed {
        logic              emit;
        logic [VERD_W-1:0] verdict;
    } acl_result_t;

    localparam acl_state_t STATE_RESET = '{phase: PH_SCAN, group_found: 1'b0,
                                           held_perm: '0};

    function automatic logic [VERD_W-1:0] covers(input logic [PERM_W-1:0] perm,
                                                 input logic [PERM_W-1:0] want);
        return ((perm & want) == want) ? V_GRANT : V_DENY;
    endfunction

endpackage

FILE: hdl/acl_in_stage.sv
// ----------------------------------------------------------------------------
// acl_in_stage
// Input register: captures one list entry word and holds it for evaluation.
// ----------------------------------------------------------------------------
module acl_in_stage
    import acl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [TAG_W-1:0]  entry_tag,
    input  logic [PERM_W-1:0] entry_perm,
    input  logic [ID_W-1:0]   entry_id,
    input  logic              caller_member,
    input  logic [ID_W-1:0]   caller_uid,
    input  logic [ID_W-1:0]   owner_uid,
    input  logic [PERM_W-1:0] want,
    input  logic              last_entry,
    input  logic              list_empty,
    input  logic              advance,
    output logic              item_valid,
    output acl_item_t         item
);

    logic      valid_reg;
    logic      valid_next;
    acl_item_t item_reg;
    logic      load;

    assign load       = !valid_reg || advance;
    assign req_stall  = !load;
    assign valid_next = load ? req_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && req_valid)
        begin
            item_reg <= '{entry_tag: entry_tag, entry_perm: entry_perm,
                          entry_id: entry_id, caller_member: caller_member,
                          caller_uid: caller_uid, owner_uid: owner_uid,
                          want: want, last_entry: last_entry,
                          list_empty: list_empty};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/acl_eval.sv
// ----------------------------------------------------------------------------
// acl_eval
// Evaluates one entry against the list state: next state and optional verdict.
// ----------------------------------------------------------------------------
module acl_eval
    import acl_pkg::*;
(
    input  acl_item_t   item,
    input  acl_state_t  state,
    output acl_state_t  state_next,
    output acl_result_t result
);

    always_comb
    begin
        acl_state_t        nxt;
        logic              dec;
        logic [VERD_W-1:0] dv;
        logic              fall;

        nxt  = state;
        dec  = 1'b0;
        dv   = V_GRANT;
        fall = 1'b0;

        case (state.phase)
            PH_DRAIN:
            begin
                if (item.last_entry)
                begin
                    nxt = STATE_RESET;
                end
            end
            PH_MASK:
            begin
                if (item.entry_tag == TAG_MASK)
                begin
                    dec = 1'b1;
                    dv  = covers(state.held_perm & item.entry_perm, item.want);
                end
                else if (item.last_entry)
                begin
                    dec = 1'b1;
                    dv  = covers(state.held_perm, item.want);
                end
            end
            default:
            begin
                case (item.entry_tag)
                    TAG_OWNER:
                    begin
                        if (item.owner_uid == item.caller_uid)
                        begin
                            dec = 1'b1;
                            dv  = covers(item.entry_perm, item.want);
                        end
                        else
                        begin
                            fall = 1'b1;
                        end
                    end
                    TAG_USER:
                    begin
                        if (item.entry_id == item.caller_uid)
                        begin
                            nxt.held_perm = item.entry_perm;
                            nxt.phase     = PH_MASK;
                            if (item.last_entry)
                            begin
                                dec = 1'b1;
                                dv  = covers(item.entry_perm, item.want);
                            end
                        end
                        else
                        begin
                            fall = 1'b1;
                        end
                    end
                    TAG_GROUPO, TAG_GROUP:
                    begin
                        if (item.caller_member)
                        begin
                            nxt.group_found = 1'b1;
                        end
                        if (item.caller_member
                            && covers(item.entry_perm, item.want) == V_GRANT)
                        begin
                            nxt.held_perm = item.entry_perm;
                            nxt.phase     = PH_MASK;
                            if (item.last_entry)
                            begin
                                dec = 1'b1;
                                dv  = V_GRANT;
                            end
                        end
                        else
                        begin
                            fall = 1'b1;
                        end
                    end
                    TAG_MASK:
                    begin
                        fall = 1'b1;
                    end
                    TAG_OTHER:
                    begin
                        dec = 1'b1;
                        dv  = state.group_found ? V_DENY
                                                : covers(item.entry_perm, item.want);
                    end
                    default:
                    begin
                        dec = 1'b1;
                        dv  = V_EIO;
                    end
                endcase
                if (fall && item.last_entry)
                begin
                    dec = 1'b1;
                    dv  = V_EIO;
                end
            end
        endcase

        if (dec)
        begin
            if (item.last_entry)
            begin
                nxt = STATE_RESET;
            end
            else
            begin
                nxt.phase = PH_DRAIN;
            end
        end

        // drop any list in progress and give a deny verdict for an empty list
        if (item.list_empty)
        begin
            nxt = STATE_RESET;
            dec = 1'b1;
            dv  = V_DENY;
        end

        state_next     = nxt;
        result.emit    = dec;
        result.verdict = dv;
    end

endmodule

FILE: hdl/acl_access_check_top.sv
// ----------------------------------------------------------------------------
// acl_access_check_top
// Access-control list checker: one list entry word per cycle while the output
// does not stall, one verdict word per list.
// ----------------------------------------------------------------------------
// Takes one entry word every cycle with no stall downstream. An entry is
// evaluated combinationally between the input register and the verdict
// register, and a verdict word shows once the verdict register captures the
// result of the entry that decides it. Only the verdict register backpressure
// stalls the input.
// ----------------------------------------------------------------------------
module acl_access_check_top
    import acl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [TAG_W-1:0]  entry_tag,
    input  logic [PERM_W-1:0] entry_perm,
    input  logic [ID_W-1:0]   entry_id,
    input  logic              caller_member,
    input  logic [ID_W-1:0]   caller_uid,
    input  logic [ID_W-1:0]   owner_uid,
    input  logic [PERM_W-1:0] want,
    input  logic              last_entry,
    input  logic              list_empty,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [VERD_W-1:0] verdict
);

    logic              item_valid;
    acl_item_t         item;
    logic              advance;
    acl_state_t        state_reg;
    acl_state_t        state_next;
    acl_result_t       result;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [VERD_W-1:0] verdict_reg;

    assign advance = !rsp_valid_reg || !rsp_stall;

    acl_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .entry_tag     (entry_tag),
        .entry_perm    (entry_perm),
        .entry_id      (entry_id),
        .caller_member (caller_member),
        .caller_uid    (caller_uid),
        .owner_uid     (owner_uid),
        .want          (want),
        .last_entry    (last_entry),
        .list_empty    (list_empty),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    acl_eval u_eval (
        .item       (item),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign rsp_valid_next = advance ? (item_valid && result.emit) : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance && item_valid)
            begin
                state_reg <= state_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid && result.emit)
        begin
            verdict_reg <= result.verdict;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign verdict   = verdict_reg;

endmodule

FILE: hdl/acl_access_check_chk.sv
// ----------------------------------------------------------------------------
// acl_access_check_chk
// Port-level checks on the access-control list checker, bound to the top.
// ----------------------------------------------------------------------------
module acl_access_check_chk
    import acl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input logic [VERD_W-1:0] verdict
);

    // hold a stalled verdict word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(verdict))
        else $error("verdict word changed while stalled");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (verdict == V_GRANT || verdict == V_DENY || verdict == V_EIO))
        else $error("undefined verdict code");

    // input stalls only under output backpressure
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled without output backpressure");

    // an idle block takes a word at once
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("input stalled while output idle");

endmodule

bind acl_access_check_top acl_access_check_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .verdict   (verdict)
);
